/* hw/rtl/assert_macros.svh */
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication, checked on the following clock edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/coaf_pkg.sv */
// shared types and constants for the circle overlap arc fraction block
`timescale 1ns / 1ps
package coaf_pkg;
    localparam int CORDIC_STEPS = 30;
    localparam int ANGLE_W      = 32;
    localparam int FRAC_W       = 17;
    localparam logic [16:0] FRACTION_ONE = 17'd65536;
    localparam logic [15:0] BARREL_RESET = 16'd2560;

    typedef enum logic [1:0] {
        CASE_CROSS   = 2'd0,
        CASE_DISJ    = 2'd1,
        CASE_BARREL  = 2'd2,
        CASE_INSIDE  = 2'd3
    } t_case;

    // atan(2^-i), pi/2 = 2^30
    function automatic logic [31:0] atan_lut(input logic [4:0] i);
        logic [31:0] v;
        begin
            case (i)
                5'd0:  v = 32'h20000000;  5'd1:  v = 32'h12E4051D;
                5'd2:  v = 32'h09FB385B;  5'd3:  v = 32'h051111D4;
                5'd4:  v = 32'h028B0D43;  5'd5:  v = 32'h0145D7E1;
                5'd6:  v = 32'h00A2F61E;  5'd7:  v = 32'h00517C55;
                5'd8:  v = 32'h0028BE53;  5'd9:  v = 32'h00145F2E;
                5'd10: v = 32'h000A2F98;  5'd11: v = 32'h000517CC;
                5'd12: v = 32'h00028BE6;  5'd13: v = 32'h000145F3;
                5'd14: v = 32'h0000A2F9;  5'd15: v = 32'h0000517C;
                5'd16: v = 32'h000028BE;  5'd17: v = 32'h0000145F;
                5'd18: v = 32'h00000A2F;  5'd19: v = 32'h00000517;
                5'd20: v = 32'h0000028B;  5'd21: v = 32'h00000145;
                5'd22: v = 32'h000000A2;  5'd23: v = 32'h00000051;
                5'd24: v = 32'h00000028;  5'd25: v = 32'h00000014;
                5'd26: v = 32'h0000000A;  5'd27: v = 32'h00000005;
                5'd28: v = 32'h00000002;  5'd29: v = 32'h00000001;
                default: v = 32'h0;
            endcase
            atan_lut = v;
        end
    endfunction
endpackage

/* hw/rtl/coaf_front.sv */
// case classification, side terms and products
`timescale 1ns / 1ps
module coaf_front #(
    parameter int LB = 16,
    parameter int PS = 0,
    parameter int PW = 60
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [LB-1:0] i_d,
    input  logic [LB-1:0] i_r,
    input  logic [LB-1:0] i_big_r,
    output logic          o_valid,
    output logic [1:0]    o_code,
    output logic          o_zero,
    output logic [PW-1:0] o_ab,
    output logic [PW-1:0] o_ce
);
    localparam int SW  = LB + 2;
    localparam int TW  = SW - PS;
    localparam int TW2 = 2 * TW;

    logic [SW-1:0] d, r, br;
    logic [SW-1:0] a_raw, b_raw, c_raw, e_raw, rnd;
    logic [1:0]    n_code;
    logic          n_cross;

    logic          r_v1, r_v2;
    logic [1:0]    r_code1, r_code2;
    logic          r_cross1;
    logic [TW-1:0] r_a, r_b, r_c, r_e;
    logic          r_zero2;
    logic [PW-1:0] r_ab, r_ce;

    assign d   = SW'(i_d);
    assign r   = SW'(i_r);
    assign br  = SW'(i_big_r);
    assign rnd = SW'((64'd1 << PS) - 64'd1);

    always_comb begin
        n_cross = 1'b0;
        if (d > br + r)        n_code = coaf_pkg::CASE_DISJ;
        else if (r > br + d)   n_code = coaf_pkg::CASE_BARREL;
        else if (br >= r + d)  n_code = coaf_pkg::CASE_INSIDE;
        else begin
            n_code  = coaf_pkg::CASE_CROSS;
            n_cross = 1'b1;
        end
        a_raw = br + r - d;
        b_raw = br + d - r;
        c_raw = d + r - br;
        e_raw = d + r + br;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        r_code1  <= n_code;
        r_cross1 <= n_cross;
        r_a <= TW'((a_raw + rnd) >> PS);
        r_b <= TW'((b_raw + rnd) >> PS);
        r_c <= TW'((c_raw + rnd) >> PS);
        r_e <= TW'((e_raw + rnd) >> PS);
        r_code2 <= r_code1;
        r_zero2 <= !r_cross1 || (r_a == '0) || (r_b == '0);
        r_ab <= PW'(TW2'(r_a) * TW2'(r_b));
        r_ce <= PW'(TW2'(r_c) * TW2'(r_e));
    end

    assign o_valid = r_v2;
    assign o_code  = r_code2;
    assign o_zero  = r_zero2;
    assign o_ab    = r_ab;
    assign o_ce    = r_ce;
endmodule

/* hw/rtl/coaf_sqrt.sv */
// pipelined integer square root, two result bits per stage
`timescale 1ns / 1ps
module coaf_sqrt #(
    parameter int PW = 60,
    parameter int SB = 2,
    parameter int CW = 3
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [CW-1:0]    i_side,
    input  logic [PW-1:0]    i_ab,
    input  logic [PW-1:0]    i_ce,
    output logic             o_valid,
    output logic [CW-1:0]    o_side,
    output logic [PW/2-1:0]  o_ys,
    output logic [PW/2-1:0]  o_xs
);
    localparam int QW = PW / 2;
    localparam int NS = QW / SB;

    logic          r_v   [NS+1];
    logic [CW-1:0] r_side[NS+1];
    logic [PW-1:0] r_ra  [NS+1];
    logic [PW-1:0] r_qa  [NS+1];
    logic [PW-1:0] r_rc  [NS+1];
    logic [PW-1:0] r_qc  [NS+1];
    logic [PW-1:0] r_va  [NS+1];
    logic [PW-1:0] r_vc  [NS+1];

    // one restoring step: remainder rem, root q, radicand v, bit index k
    function automatic logic [2*PW-1:0] step(input logic [PW-1:0] rem,
                                             input logic [PW-1:0] q,
                                             input logic [PW-1:0] v,
                                             input int k);
        logic [PW+1:0] tr, tt;
        logic [PW-1:0] nq;
        begin
            tr = {rem, v[2*k+1 -: 2]};
            tt = {q, 2'b01};
            if (tr >= tt) begin
                tr = tr - tt;
                nq = {q[PW-2:0], 1'b1};
            end else begin
                nq = {q[PW-2:0], 1'b0};
            end
            step = {PW'(tr), nq};
        end
    endfunction

    assign r_v[0]    = i_valid;
    assign r_side[0] = i_side;
    assign r_ra[0]   = '0;
    assign r_qa[0]   = '0;
    assign r_rc[0]   = '0;
    assign r_qc[0]   = '0;
    assign r_va[0]   = i_ab;
    assign r_vc[0]   = i_ce;

    for (genvar s = 0; s < NS; s++) begin : g_st
        logic [PW-1:0] ra, qa, rc, qc;
        always_comb begin
            ra = r_ra[s]; qa = r_qa[s]; rc = r_rc[s]; qc = r_qc[s];
            for (int j = 0; j < SB; j++) begin
                {ra, qa} = step(ra, qa, r_va[s], QW - 1 - s*SB - j);
                {rc, qc} = step(rc, qc, r_vc[s], QW - 1 - s*SB - j);
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v[s+1] <= 1'b0;
            else          r_v[s+1] <= r_v[s];
            r_side[s+1] <= r_side[s];
            r_ra[s+1] <= ra; r_qa[s+1] <= qa;
            r_rc[s+1] <= rc; r_qc[s+1] <= qc;
            r_va[s+1] <= r_va[s]; r_vc[s+1] <= r_vc[s];
        end
    end

    assign o_valid = r_v[NS];
    assign o_side  = r_side[NS];
    assign o_ys    = QW'(r_qa[NS]);
    assign o_xs    = QW'(r_qc[NS]);
endmodule

/* hw/rtl/coaf_cordic.sv */
// normalising shift and pipelined vectoring cordic
`timescale 1ns / 1ps
module coaf_cordic #(
    parameter int QW = 30,
    parameter int CW = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [CW-1:0]         i_side,
    input  logic [QW-1:0]         i_ys,
    input  logic [QW-1:0]         i_xs,
    output logic                  o_valid,
    output logic [CW-1:0]         o_side,
    output logic [16:0]           o_frac
);
    localparam int NST = coaf_pkg::CORDIC_STEPS;
    localparam int XW  = 34;
    localparam int LW  = (QW > 31) ? QW : 31;
    localparam int NB  = 5;

    // normalisation: left shift by up to 31 in binary-weighted stages
    logic          r_nv [NB+1];
    logic [CW-1:0] r_ns [NB+1];
    logic [LW-1:0] r_nx [NB+1];
    logic [LW-1:0] r_ny [NB+1];

    assign r_nv[0] = i_valid;
    assign r_ns[0] = i_side;
    assign r_nx[0] = LW'(i_xs);
    assign r_ny[0] = LW'(i_ys);

    for (genvar b = 0; b < NB; b++) begin : g_norm
        localparam int SH = 1 << (NB - 1 - b);
        logic [LW-1:0] mx, tx, ty;
        always_comb begin
            mx = r_nx[b] | r_ny[b];
            tx = r_nx[b];
            ty = r_ny[b];
            // shift only while the leading one stays at or below bit 30
            if (mx < (LW'(1) << (31 - SH))) begin
                tx = r_nx[b] << SH;
                ty = r_ny[b] << SH;
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_nv[b+1] <= 1'b0;
            else          r_nv[b+1] <= r_nv[b];
            r_ns[b+1] <= r_ns[b];
            r_nx[b+1] <= tx;
            r_ny[b+1] <= ty;
        end
    end

    // cordic rotations, one per stage
    logic                 r_cv [NST+1];
    logic [CW-1:0]        r_cs [NST+1];
    logic signed [XW-1:0] r_x  [NST+1];
    logic signed [XW-1:0] r_y  [NST+1];
    logic signed [33:0]   r_z  [NST+1];

    assign r_cv[0] = r_nv[NB];
    assign r_cs[0] = r_ns[NB];
    assign r_x[0]  = XW'(r_nx[NB]);
    assign r_y[0]  = XW'(r_ny[NB]);
    assign r_z[0]  = '0;

    for (genvar i = 0; i < NST; i++) begin : g_rot
        logic signed [XW-1:0] xs, ys;
        logic signed [33:0]   at;
        always_comb begin
            xs = r_x[i][XW-1] ? -((-r_x[i]) >>> i) : (r_x[i] >>> i);
            ys = r_y[i][XW-1] ? -((-r_y[i]) >>> i) : (r_y[i] >>> i);
            at = 34'(coaf_pkg::atan_lut(5'(i)));
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_cv[i+1] <= 1'b0;
            else          r_cv[i+1] <= r_cv[i];
            r_cs[i+1] <= r_cs[i];
            if (!r_y[i][XW-1]) begin
                r_x[i+1] <= r_x[i] + ys;
                r_y[i+1] <= r_y[i] - xs;
                r_z[i+1] <= r_z[i] + at;
            end else begin
                r_x[i+1] <= r_x[i] - ys;
                r_y[i+1] <= r_y[i] + xs;
                r_z[i+1] <= r_z[i] - at;
            end
        end
    end

    // clamp and round to q1.16
    logic [30:0] zc;
    logic        r_ov;
    logic [CW-1:0] r_os;
    logic [16:0] r_of;
    always_comb begin
        if (r_z[NST][33])                      zc = '0;
        else if (r_z[NST] > 34'sd1073741824)   zc = 31'd1073741824;
        else                                   zc = 31'(r_z[NST]);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else          r_ov <= r_cv[NST];
        r_os <= r_cs[NST];
        r_of <= 17'((32'(zc) + 32'd8192) >> 14);
    end

    assign o_valid = r_ov;
    assign o_side  = r_os;
    assign o_frac  = r_of;
endmodule

/* hw/rtl/circle_overlap_arc_fraction.sv */
// top level of the circle overlap arc fraction pipeline
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+------------------------------
//  input   | i_center_distance, i_curl_radius        | start high, busy low
//  result  | o_inside_fraction, o_case_code          | o_strobe, one cycle, no stall
//  config  | i_cfg_data                              | i_cfg_we, single register
//
// one beat enters per cycle; busy is always low
// pipeline stages at the default lengths: 2 front stages,
// 9 square root stages (two bits each), 5 normalising stages, 30 cordic stages,
// 1 rounding stage, 1 output stage
// synchronous active-low reset clears valid bits and loads the barrel radius
// the receiver cannot stall so nothing ever holds back the pipeline
`timescale 1ns / 1ps
`include "assert_macros.svh"
module circle_overlap_arc_fraction #(
    parameter int LENGTH_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_center_distance,
    input  logic [15:0] i_curl_radius,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    output logic        o_strobe,
    output logic [16:0] o_inside_fraction,
    output logic [1:0]  o_case_code
);
    // lengths used after masking to LENGTH_BITS, at most 16 bits
    localparam int LB = (LENGTH_BITS < 16) ? LENGTH_BITS : 16;
    // side terms are scaled down, rounding up, when the length width exceeds 29
    localparam int PS = (LENGTH_BITS > 29) ? LENGTH_BITS - 29 : 0;
    localparam int TW = LB + 2 - PS;
    localparam int QW = TW + (TW % 2);
    localparam int PW = 2 * QW;
    localparam int CW = 3;

    logic [15:0] r_barrel;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)      r_barrel <= coaf_pkg::BARREL_RESET;
        else if (i_cfg_we) r_barrel <= i_cfg_data;
    end

    assign busy = 1'b0;

    logic          f_v, f_zero;
    logic [1:0]    f_code;
    logic [PW-1:0] f_ab, f_ce;

    coaf_front #(.LB(LB), .PS(PS), .PW(PW)) u_front (
        .i_clk, .i_rst_n,
        .i_valid (start),
        .i_d     (i_center_distance[LB-1:0]),
        .i_r     (i_curl_radius[LB-1:0]),
        .i_big_r (r_barrel[LB-1:0]),
        .o_valid (f_v), .o_code(f_code), .o_zero(f_zero),
        .o_ab    (f_ab), .o_ce(f_ce)
    );

    logic          s_v;
    logic [CW-1:0] s_side;
    logic [QW-1:0] s_ys, s_xs;

    // side band: zero flag and case code ride along
    coaf_sqrt #(.PW(PW), .SB(2), .CW(CW)) u_sqrt (
        .i_clk, .i_rst_n,
        .i_valid (f_v),
        .i_side  ({f_zero, f_code}),
        .i_ab    (f_ab), .i_ce(f_ce),
        .o_valid (s_v), .o_side(s_side),
        .o_ys    (s_ys), .o_xs(s_xs)
    );

    logic          c_v;
    logic [CW-1:0] c_side;
    logic [16:0]   c_frac;

    coaf_cordic #(.QW(QW), .CW(CW)) u_cordic (
        .i_clk, .i_rst_n,
        .i_valid (s_v), .i_side(s_side),
        .i_ys    (s_ys), .i_xs(s_xs),
        .o_valid (c_v), .o_side(c_side), .o_frac(c_frac)
    );

    logic        r_strobe;
    logic [16:0] r_frac;
    logic [1:0]  r_code;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_strobe <= 1'b0;
        else          r_strobe <= c_v;
        r_code <= c_side[1:0];
        if (c_side[1:0] == coaf_pkg::CASE_INSIDE) r_frac <= coaf_pkg::FRACTION_ONE;
        else if (c_side[2])                       r_frac <= '0;
        else                                      r_frac <= c_frac;
    end

    assign o_strobe          = r_strobe;
    assign o_inside_fraction = r_frac;
    assign o_case_code       = r_code;

    // result never exceeds 1.0
    `ASSERT_CLK(a_frac_max, i_clk, i_rst_n,
        !r_strobe || r_frac <= coaf_pkg::FRACTION_ONE, "fraction above one")
    // non-crossing cases other than inside give zero
    `ASSERT_CLK(a_zero_cases, i_clk, i_rst_n,
        !r_strobe || !(r_code == coaf_pkg::CASE_DISJ || r_code == coaf_pkg::CASE_BARREL)
        || r_frac == '0, "disjoint case not zero")
    // inside case gives exactly one
    `ASSERT_NEXT(a_inside_one, i_clk, i_rst_n,
        c_v && c_side[1:0] == coaf_pkg::CASE_INSIDE, r_frac == coaf_pkg::FRACTION_ONE,
        "inside case not one")
endmodule
